@@ hw/rtl/sidasc_pkg.sv @@
// Shared types and character/BCD constants for the decimal text converter.
`timescale 1ns / 1ps
`default_nettype none
package sidasc_pkg;

	typedef logic [5:0] char_t;
	typedef logic [3:0] digit_t;

	localparam char_t  CHAR_MINUS    = 6'd45;
	localparam char_t  CHAR_ZERO     = 6'd48;
	localparam digit_t BCD_ADJ_LIMIT = 4'd5;
	localparam digit_t BCD_ADJ       = 4'd3;

endpackage
`default_nettype wire

@@ hw/rtl/signed_int_to_decimal_ascii.sv @@
// Top level: signed integer to decimal ASCII text, one character per strobe.
//
// channel  | ports                      | handshake
// request  | value                      | taken when start && !busy
// result   | text_char, is_last         | strobe, one cycle, no backpressure
//
// A request runs one shift-and-add-3 step per value bit in the BCD step module,
// then strobes the minus sign if the value is negative, then visits each BCD digit
// position in turn (leading zeros are dropped without a strobe).
// busy stays high from acceptance until the last character is strobed.
// arst_n clears the sequencer and strobe; no state survives between requests.
`timescale 1ns / 1ps
`default_nettype none
module signed_int_to_decimal_ascii import sidasc_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	output logic                               strobe,
	output logic             [5:0]             text_char,
	output logic                               is_last
);

	localparam int ND = ((VALUE_WIDTH * 1233) >> 12) + 1;
	localparam int CW = $clog2(VALUE_WIDTH);
	localparam int DW = (ND > 1) ? $clog2(ND) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SIGN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]             state_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [4*ND-1:0]        bcd_q;
	logic [4*ND-1:0]        bcd_next;
	logic                   neg_q;
	logic                   seen_q;
	logic [CW-1:0]          bit_cnt_q;
	logic [DW-1:0]          dig_cnt_q;
	logic                   strobe_q;
	char_t                  char_q;
	logic                   last_q;
	digit_t                 top_digit;
	logic                   end_pos;
	logic [VALUE_WIDTH-1:0] value_u;

	assign value_u   = value;
	assign top_digit = bcd_q[4*ND-1 -: 4];
	assign end_pos   = (dig_cnt_q == DW'(ND - 1));

	sidasc_bcd_step #(
		.ND(ND)
	) u_step (
		.bcd_in  (bcd_q),
		.shift_in(mag_q[VALUE_WIDTH-1]),
		.bcd_out (bcd_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			seen_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
						seen_q  <= 1'b0;
					end
				end
				ST_CONV: begin
					if (bit_cnt_q == CW'(VALUE_WIDTH - 1)) begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (top_digit != '0 || seen_q || end_pos) begin
						strobe_q <= 1'b1;
						seen_q   <= 1'b1;
					end
					if (end_pos) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				neg_q     <= value_u[VALUE_WIDTH-1];
				mag_q     <= value_u[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;
				bcd_q     <= '0;
				bit_cnt_q <= '0;
				dig_cnt_q <= '0;
			end
			ST_CONV: begin
				bcd_q     <= bcd_next;
				mag_q     <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			ST_SIGN: begin
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
			end
			ST_EMIT: begin
				char_q    <= CHAR_ZERO + {2'b00, top_digit};
				last_q    <= end_pos;
				bcd_q     <= {bcd_q[4*ND-5:0], 4'b0000};
				dig_cnt_q <= dig_cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign text_char = char_q;
	assign is_last   = last_q;

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && is_last) |-> !busy)
		else $error("last character strobed while still busy");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !is_last) |-> busy)
		else $error("text ended without end marker");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !strobe))
		else $error("accepted request did not start conversion");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && text_char == CHAR_MINUS) |-> !is_last)
		else $error("minus sign marked as last character");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (text_char == CHAR_MINUS ||
			(text_char >= CHAR_ZERO && text_char <= CHAR_ZERO + 6'd9)))
		else $error("illegal character code");

endmodule
`default_nettype wire

@@ hw/rtl/sidasc_bcd_step.sv @@
// One shift-and-add-3 step of the binary to BCD conversion.
`timescale 1ns / 1ps
`default_nettype none
module sidasc_bcd_step import sidasc_pkg::*; #(
	parameter int ND = 10
) (
	input  wire logic [4*ND-1:0] bcd_in,
	input  wire logic            shift_in,
	output logic      [4*ND-1:0] bcd_out
);

	logic [4*ND-1:0] adj;

	always_comb begin
		for (int i = 0; i < ND; i++) begin
			if (bcd_in[4*i +: 4] >= BCD_ADJ_LIMIT) begin
				adj[4*i +: 4] = bcd_in[4*i +: 4] + BCD_ADJ;
			end else begin
				adj[4*i +: 4] = bcd_in[4*i +: 4];
			end
		end
		bcd_out = {adj[4*ND-2:0], shift_in};
	end

endmodule
`default_nettype wire

@@ verif/signed_int_to_decimal_ascii_tb.sv @@
// Testbench for signed_int_to_decimal_ascii: directed and random requests checked per character.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_tb;
	import sidasc_pkg::*;

	localparam int VW = 32;

	typedef struct packed {
		char_t code;
		logic  is_end;
	} text_item_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [VW-1:0] value;
	logic                 strobe;
	logic [5:0]           text_char;
	logic                 is_last;

	text_item_t pending_text[$];
	int         error_count;

	signed_int_to_decimal_ascii #(.VALUE_WIDTH(VW)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.strobe(strobe),
		.text_char(text_char),
		.is_last(is_last)
	);

	always #5 clk = ~clk;

	function automatic void predict_text(input logic [VW-1:0] v);
		logic [63:0] mag;
		char_t       digs[$];
		text_item_t  it;
		if (v[VW-1]) begin
			mag = {32'b0, (~v) + 32'd1};
			if (mag == 64'd0)
				mag = 64'h8000_0000;
		end else begin
			mag = {32'b0, v};
		end
		do begin
			digs.push_front(CHAR_ZERO + char_t'(mag % 64'd10));
			mag = mag / 64'd10;
		end while (mag != 64'd0);
		if (v[VW-1]) begin
			it.code = CHAR_MINUS;
			it.is_end = 1'b0;
			pending_text.push_back(it);
		end
		foreach (digs[i]) begin
			it.code = digs[i];
			it.is_end = (i == digs.size() - 1);
			pending_text.push_back(it);
		end
	endfunction

	// start stays high on return; idle_gap lowers it
	task automatic send_request(input logic [VW-1:0] v);
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_text(v);
	endtask

	task automatic idle_gap(input int n);
		@(negedge clk);
		start <= 1'b0;
		value <= $urandom;
		repeat (n - 1)
			@(negedge clk);
	endtask

	function automatic logic [VW-1:0] random_by_digits();
		int unsigned d;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mag;
		d = $urandom_range(1, 10);
		lo = (d == 1) ? 0 : 1;
		for (int i = 1; i < d; i++)
			lo = lo * 10;
		hi = (d == 1) ? 9 : lo * 10 - 1;
		if (hi > 64'd2147483647)
			hi = 64'd2147483647;
		mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
		if ($urandom_range(0, 1))
			return (~mag[VW-1:0]) + 1;
		return mag[VW-1:0];
	endfunction

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_text.size() == 0) begin
				$display("%0t: unexpected character: expected none, got %0d last %0d",
					$time, text_char, is_last);
				error_count++;
			end else begin
				if (text_char !== pending_text[0].code) begin
					$display("%0t: text_char expected %0d got %0d",
						$time, pending_text[0].code, text_char);
					error_count++;
				end
				if (is_last !== pending_text[0].is_end) begin
					$display("%0t: is_last expected %0d got %0d",
						$time, pending_text[0].is_end, is_last);
					error_count++;
				end
				void'(pending_text.pop_front());
			end
		end
	end

	task automatic test_directed_values();
		logic [VW-1:0] vals[$];
		vals = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
			-32'sd100, 32'd12345, -32'sd67890, 32'd999999999, 32'd1000000000,
			-32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
			32'd1234567890, 32'hC000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
		foreach (vals[i]) begin
			send_request(vals[i]);
			if (i % 3 == 1)
				idle_gap($urandom_range(1, 16));
		end
	endtask

	task automatic test_random_with_gaps(input int n);
		bit gaps_on;
		gaps_on = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				gaps_on = ~gaps_on;
			if ($urandom_range(0, 1))
				send_request($urandom);
			else
				send_request(random_by_digits());
			if (gaps_on && $urandom_range(0, 2) == 0)
				idle_gap($urandom_range(1, 16));
		end
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 3; i++) begin
			idle_gap(1);
			while (pending_text.size() != 0)
				@(posedge clk);
			send_request(random_by_digits());
		end
	endtask

	task automatic test_back_to_back(input int n);
		for (int i = 0; i < n; i++)
			send_request((i % 2) ? $urandom : random_by_digits());
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		error_count = 0;
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_values();
		test_random_with_gaps(180);
		test_drain_pause();
		test_back_to_back(60);

		@(negedge clk);
		start <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (60)
			@(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
